/* rtl/core/bmp24_stream_parser_core_defines.svh */
// Assertion macros for the bmp24 stream parser.
`ifndef BMP24_STREAM_PARSER_CORE_DEFINES_SVH
`define BMP24_STREAM_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
`define BMP24_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BMP24_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define BMP24_ASSERT(name, prop, msg)
`define BMP24_ASSERT_NEXT(name, cond, prop, msg)
`endif

`endif

/* rtl/core/bmp24_pkg.sv */
package bmp24_pkg;

  localparam int COORD_BITS = 16;
  localparam int WIDE_BITS  = 33;
  localparam int HDR_LEN    = 54;
  localparam int PIX_DEPTH  = 24;

  localparam logic [WIDE_BITS-1:0] COORD_MAX =
    (WIDE_BITS'(1) << COORD_BITS) - WIDE_BITS'(1);

  localparam logic [5:0] WIDTH_FIRST  = 6'd18;
  localparam logic [5:0] WIDTH_LAST   = 6'd21;
  localparam logic [5:0] HEIGHT_FIRST = 6'd22;
  localparam logic [5:0] HEIGHT_LAST  = 6'd25;
  localparam logic [5:0] DEPTH_FIRST  = 6'd28;
  localparam logic [5:0] DEPTH_LAST   = 6'd29;
  localparam logic [5:0] COMP_FIRST   = 6'd30;
  localparam logic [5:0] COMP_LAST    = 6'd33;
  localparam logic [5:0] HDR_FINAL    = 6'(HDR_LEN - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS,
    PH_DROP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TRI_BLUE,
    TRI_GREEN,
    TRI_RED
  } tri_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_pixel;
  } out_item_t;

endpackage

/* rtl/core/bmp24_if.sv */
interface bmp24_in_if import bmp24_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bmp24_out_if import bmp24_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/bmp24_stream_parser_core.sv */
// The byte transfer that completes a result (third byte of a pixel, last header byte) also
// loads it into the output register. Throughput: one byte per cycle while result is ready
// or the output is empty; the single output register refills on the cycle it drains.
// Reset (rst, synchronous, active high): parser idle, counters cleared, output empty.
// Bytes are ignored until one arrives with start_of_file set.
`include "bmp24_stream_parser_core_defines.svh"

module bmp24_stream_parser_core import bmp24_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bmp24_in_if.sink     byte_in,
  bmp24_out_if.source  result
);

  phase_t                phase, phase_next;
  logic [5:0]            header_index, header_index_next;
  logic [31:0]           width_reg, height_reg, compression_reg;
  logic [15:0]           depth_bits;
  logic [COORD_BITS-1:0] column_count, column_count_next;
  logic [COORD_BITS-1:0] row_count, row_count_next;
  tri_t                  triple_index, triple_index_next;
  logic [7:0]            held_blue, held_blue_next;
  logic [7:0]            held_green, held_green_next;
  logic [1:0]            pad_left, pad_left_next;
  logic                  out_valid;
  out_item_t             out_data;

  logic                  accept, sof;
  logic [7:0]            b;
  phase_t                eff_phase;
  logic [5:0]            eff_hidx;
  logic [31:0]           width_cur, height_cur, comp_cur;
  logic [15:0]           depth_cur;
  logic [COORD_BITS-1:0] col_eff, row_eff;
  tri_t                  tri_eff;
  logic [1:0]            pad_eff;
  logic                  hdr_in, hdr_last, hdr_bad, img_empty;
  logic [31:0]           width_hdr, height_hdr, comp_hdr;
  logic [15:0]           depth_hdr;
  logic                  pix_in, pix_emit, col_end, row_end;
  logic [WIDE_BITS-1:0]  col_plus, row_plus;
  logic                  res_valid;
  out_item_t             res_data;

  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] sel,
                                           input logic [7:0] val);
    logic [31:0] w;
    w = word;
    w[8*sel +: 8] = val;
    return w;
  endfunction

  assign accept = byte_in.valid && byte_in.ready;
  assign byte_in.ready = !out_valid || result.ready;
  assign sof = byte_in.data.start_of_file;
  assign b = byte_in.data.data_byte;

  // start_of_file restarts the parse on this very byte
  assign eff_phase  = sof ? PH_HEADER : phase;
  assign eff_hidx   = sof ? 6'd0 : header_index;
  assign width_cur  = sof ? 32'd0 : width_reg;
  assign height_cur = sof ? 32'd0 : height_reg;
  assign comp_cur   = sof ? 32'd0 : compression_reg;
  assign depth_cur  = sof ? 16'd0 : depth_bits;
  assign col_eff    = sof ? '0 : column_count;
  assign row_eff    = sof ? '0 : row_count;
  assign tri_eff    = sof ? TRI_BLUE : triple_index;
  assign pad_eff    = sof ? 2'd0 : pad_left;

  assign hdr_in = eff_phase == PH_HEADER;
  assign width_hdr = (hdr_in && eff_hidx >= WIDTH_FIRST && eff_hidx <= WIDTH_LAST) ?
                     put_byte(width_cur, eff_hidx[1:0] + 2'd2, b) : width_cur;
  assign height_hdr = (hdr_in && eff_hidx >= HEIGHT_FIRST && eff_hidx <= HEIGHT_LAST) ?
                      put_byte(height_cur, eff_hidx[1:0] + 2'd2, b) : height_cur;
  assign depth_hdr = (hdr_in && eff_hidx >= DEPTH_FIRST && eff_hidx <= DEPTH_LAST) ?
                     16'(put_byte({16'd0, depth_cur}, eff_hidx[1:0], b)) : depth_cur;
  assign comp_hdr = (hdr_in && eff_hidx >= COMP_FIRST && eff_hidx <= COMP_LAST) ?
                    put_byte(comp_cur, eff_hidx[1:0] + 2'd2, b) : comp_cur;

  assign hdr_last  = hdr_in && (eff_hidx == HDR_FINAL);
  assign hdr_bad   = (depth_hdr != 16'(PIX_DEPTH)) || (comp_hdr != 32'd0) ||
                     (WIDE_BITS'(width_hdr) > COORD_MAX) ||
                     (WIDE_BITS'(height_hdr) > COORD_MAX);
  assign img_empty = (width_hdr == 32'd0) || (height_hdr == 32'd0);

  assign pix_in   = eff_phase == PH_PIXELS;
  assign pix_emit = pix_in && (pad_eff == 2'd0) && (tri_eff == TRI_RED);
  assign col_plus = WIDE_BITS'(col_eff) + WIDE_BITS'(1);
  assign row_plus = WIDE_BITS'(row_eff) + WIDE_BITS'(1);
  assign col_end  = col_plus >= WIDE_BITS'(width_cur);
  assign row_end  = row_plus >= WIDE_BITS'(height_cur);

  always_comb begin
    phase_next        = eff_phase;
    header_index_next = eff_hidx;
    column_count_next = col_eff;
    row_count_next    = row_eff;
    triple_index_next = tri_eff;
    held_blue_next    = held_blue;
    held_green_next   = held_green;
    pad_left_next     = pad_eff;
    case (eff_phase)
      PH_HEADER: begin
        if (hdr_last) begin
          header_index_next = 6'd0;
          column_count_next = '0;
          row_count_next    = '0;
          triple_index_next = TRI_BLUE;
          pad_left_next     = 2'd0;
          if (hdr_bad) begin
            phase_next = PH_DROP;
          end else if (img_empty) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_PIXELS;
          end
        end else begin
          header_index_next = eff_hidx + 6'd1;
        end
      end
      PH_PIXELS: begin
        if (pad_eff != 2'd0) begin
          pad_left_next = pad_eff - 2'd1;
        end else begin
          case (tri_eff)
            TRI_BLUE: begin
              held_blue_next    = b;
              triple_index_next = TRI_GREEN;
            end
            TRI_GREEN: begin
              held_green_next   = b;
              triple_index_next = TRI_RED;
            end
            default: begin
              triple_index_next = TRI_BLUE;
              if (col_end) begin
                column_count_next = '0;
                if (row_end) begin
                  phase_next     = PH_IDLE;
                  row_count_next = '0;
                end else begin
                  row_count_next = COORD_BITS'(row_plus);
                  pad_left_next  = width_cur[1:0];
                end
              end else begin
                column_count_next = COORD_BITS'(col_plus);
              end
            end
          endcase
        end
      end
      default: begin
        phase_next = eff_phase;
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res_data  = '0;
    if (hdr_last) begin
      res_valid = 1'b1;
      if (hdr_bad) begin
        res_data.kind = KIND_REJECT;
      end else begin
        res_data.kind         = KIND_ACCEPT;
        res_data.image_width  = width_hdr[15:0];
        res_data.image_height = height_hdr[15:0];
      end
    end else if (pix_emit) begin
      res_valid           = 1'b1;
      res_data.kind       = KIND_PIXEL;
      res_data.red        = b;
      res_data.green      = held_green;
      res_data.blue       = held_blue;
      res_data.column     = 16'(col_eff);
      res_data.row        = 16'(row_eff);
      res_data.last_pixel = col_end && row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_index    <= 6'd0;
      width_reg       <= 32'd0;
      height_reg      <= 32'd0;
      depth_bits      <= 16'd0;
      compression_reg <= 32'd0;
      column_count    <= '0;
      row_count       <= '0;
      triple_index    <= TRI_BLUE;
      held_blue       <= 8'd0;
      held_green      <= 8'd0;
      pad_left        <= 2'd0;
      out_valid       <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      width_reg       <= width_hdr;
      height_reg      <= height_hdr;
      depth_bits      <= depth_hdr;
      compression_reg <= comp_hdr;
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      triple_index    <= triple_index_next;
      held_blue       <= held_blue_next;
      held_green      <= held_green_next;
      pad_left        <= pad_left_next;
      out_valid       <= res_valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_data;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  `BMP24_ASSERT(a_hidx_range, (phase == PH_HEADER) |-> (header_index <= HDR_FINAL), "header index past end")
  `BMP24_ASSERT(a_pad_only_pixels, (pad_left != 2'd0) |-> ((phase == PH_PIXELS) && (triple_index == TRI_BLUE)), "pad count outside pixel phase")
  `BMP24_ASSERT(a_coord_bound, (phase == PH_PIXELS) |-> ((WIDE_BITS'(column_count) < WIDE_BITS'(width_reg)) && (WIDE_BITS'(row_count) < WIDE_BITS'(height_reg))), "pixel position outside image")
  `BMP24_ASSERT_NEXT(a_last_idle, accept && res_valid && (res_data.kind == KIND_PIXEL) && res_data.last_pixel, (phase == PH_IDLE) && result.valid, "last pixel did not end image")

endmodule

/* test/bmp24_parse_checker.sv */
module bmp24_parse_checker import bmp24_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bmp24_in_if         byte_ch,
  bmp24_out_if        res_ch,
  output int          pending,
  output int          errors,
  output int          n_pixels,
  output int          n_accepts,
  output int          n_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t      stage;
  logic [5:0]  hdr_pos;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [15:0] bpp;
  logic [31:0] cmp;
  logic [15:0] col;
  logic [15:0] rw;
  tri_t        chan;
  logic [7:0]  blue_q;
  logic [7:0]  green_q;
  logic [1:0]  pad_cnt;
  out_item_t   expected_q[$];

  function automatic logic [31:0] set_lane(logic [31:0] w, int lane, logic [7:0] b);
    w[lane*8 +: 8] = b;
    return w;
  endfunction

  task automatic parse_byte(input in_item_t it);
    out_item_t r;
    logic [7:0] b;
    r = '0;
    b = it.data_byte;
    if (it.start_of_file) begin
      stage   = PH_HEADER;
      hdr_pos = '0;
      img_w   = '0;
      img_h   = '0;
      bpp     = '0;
      cmp     = '0;
      col     = '0;
      rw      = '0;
      chan    = TRI_BLUE;
      pad_cnt = '0;
    end
    case (stage)
      PH_HEADER: begin
        if (hdr_pos >= WIDTH_FIRST && hdr_pos <= WIDTH_LAST)
          img_w = set_lane(img_w, hdr_pos - WIDTH_FIRST, b);
        else if (hdr_pos >= HEIGHT_FIRST && hdr_pos <= HEIGHT_LAST)
          img_h = set_lane(img_h, hdr_pos - HEIGHT_FIRST, b);
        else if (hdr_pos >= DEPTH_FIRST && hdr_pos <= DEPTH_LAST)
          bpp = 16'(set_lane(32'(bpp), hdr_pos - DEPTH_FIRST, b));
        else if (hdr_pos >= COMP_FIRST && hdr_pos <= COMP_LAST)
          cmp = set_lane(cmp, hdr_pos - COMP_FIRST, b);
        if (hdr_pos != HDR_FINAL) begin
          hdr_pos++;
        end else begin
          hdr_pos = '0;
          if (bpp != 16'(PIX_DEPTH) || cmp != '0 ||
              {1'b0, img_w} > COORD_MAX || {1'b0, img_h} > COORD_MAX) begin
            stage  = PH_DROP;
            r.kind = KIND_REJECT;
          end else begin
            r.kind         = KIND_ACCEPT;
            r.image_width  = img_w[15:0];
            r.image_height = img_h[15:0];
            col     = '0;
            rw      = '0;
            chan    = TRI_BLUE;
            pad_cnt = '0;
            stage   = (img_w == '0 || img_h == '0) ? PH_IDLE : PH_PIXELS;
          end
          expected_q.push_back(r);
        end
      end
      PH_PIXELS: begin
        if (pad_cnt != '0) begin
          pad_cnt--;
        end else begin
          case (chan)
            TRI_BLUE: begin
              blue_q = b;
              chan   = TRI_GREEN;
            end
            TRI_GREEN: begin
              green_q = b;
              chan    = TRI_RED;
            end
            default: begin
              chan     = TRI_BLUE;
              r.kind   = KIND_PIXEL;
              r.red    = b;
              r.green  = green_q;
              r.blue   = blue_q;
              r.column = col;
              r.row    = rw;
              if (WIDE_BITS'(col) + WIDE_BITS'(1) >= WIDE_BITS'(img_w)) begin
                col = '0;
                if (WIDE_BITS'(rw) + WIDE_BITS'(1) >= WIDE_BITS'(img_h)) begin
                  r.last_pixel = 1'b1;
                  stage        = PH_IDLE;
                  rw           = '0;
                end else begin
                  rw++;
                  pad_cnt = img_w[1:0];
                end
              end else begin
                col++;
              end
              expected_q.push_back(r);
            end
          endcase
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      $error("transfer on result with nothing expected: kind %0d", got.kind);
      errors++;
    end else begin
      want = expected_q.pop_front();
      check_field("kind", 16'(want.kind), 16'(got.kind));
      check_field("red", 16'(want.red), 16'(got.red));
      check_field("green", 16'(want.green), 16'(got.green));
      check_field("blue", 16'(want.blue), 16'(got.blue));
      check_field("column", want.column, got.column);
      check_field("row", want.row, got.row);
      check_field("image_width", want.image_width, got.image_width);
      check_field("image_height", want.image_height, got.image_height);
      check_field("last_pixel", 16'(want.last_pixel), 16'(got.last_pixel));
      case (want.kind)
        KIND_PIXEL:  n_pixels++;
        KIND_ACCEPT: n_accepts++;
        default:     n_rejects++;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stage     = PH_IDLE;
      hdr_pos   = '0;
      img_w     = '0;
      img_h     = '0;
      bpp       = '0;
      cmp       = '0;
      col       = '0;
      rw        = '0;
      chan      = TRI_BLUE;
      blue_q    = '0;
      green_q   = '0;
      pad_cnt   = '0;
      errors    = 0;
      n_pixels  = 0;
      n_accepts = 0;
      n_rejects = 0;
      expected_q.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) check_result(res_ch.data);
      if (byte_ch.valid && byte_ch.ready) parse_byte(byte_ch.data);
    end
    pending <= expected_q.size();
  end

endmodule

/* test/tb_bmp24_stream_parser_core.sv */
module tb_bmp24_stream_parser_core import bmp24_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 750;

  logic clk;
  logic rst;
  int   pending;
  int   errors;
  int   n_pixels;
  int   n_accepts;
  int   n_rejects;
  int   cycles = 0;
  int   bytes_sent = 0;
  int   files_sent = 0;
  int   stall_left;
  bit   tx_burst = 1'b0;
  bit   rx_burst;

  bmp24_in_if  byte_ch ();
  bmp24_out_if res_ch ();

  bmp24_stream_parser_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .result  (res_ch)
  );

  bmp24_parse_checker i_chk (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .res_ch    (res_ch),
    .pending   (pending),
    .errors    (errors),
    .n_pixels  (n_pixels),
    .n_accepts (n_accepts),
    .n_rejects (n_rejects)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles with %0d results outstanding", CYCLE_LIMIT, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result-side backpressure
  initial begin
    res_ch.ready = 1'b0;
    stall_left   = 0;
    rx_burst     = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) rx_burst = !rx_burst;
      if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (!rx_burst && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int image_bytes(int w, int h);
    return h * (3 * w + w % 4);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sof);
    in_item_t it;
    int gap;
    it.data_byte     = b;
    it.start_of_file = sof;
    gap = pick_gap();
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data  <= it;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // fill < 0 gives random pixel bytes; cut is the number of file bytes sent
  task automatic append_file(input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] bpp, input logic [31:0] cmp,
                             input int fill, input int cut, input int trail);
    logic [7:0] hdr [HDR_LEN];
    logic [7:0] b;
    int i;
    for (i = 0; i < HDR_LEN; i++) hdr[i] = 8'($urandom);
    for (i = 0; i < 4; i++) begin
      hdr[WIDTH_FIRST + i]  = w[8*i +: 8];
      hdr[HEIGHT_FIRST + i] = h[8*i +: 8];
      hdr[COMP_FIRST + i]   = cmp[8*i +: 8];
    end
    hdr[DEPTH_FIRST] = bpp[7:0];
    hdr[DEPTH_LAST]  = bpp[15:8];
    for (i = 0; i < cut; i++) begin
      if (i < HDR_LEN) b = hdr[i];
      else if (fill < 0) b = 8'($urandom);
      else b = 8'(fill);
      send_byte(b, i == 0);
    end
    for (i = 0; i < trail; i++) send_byte(8'($urandom), 1'b0);
    files_sent++;
  endtask

  initial begin : stim
    int w;
    int h;
    int full;
    int cut;
    int pick;
    logic [15:0] bpp;
    logic [31:0] cmp;
    logic [31:0] big_w;
    logic [31:0] big_h;

    rst           = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // bytes before any start marker are ignored
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    // restart inside the header, then a 1x1 white image with trailing bytes
    append_file(3, 2, 16'(PIX_DEPTH), 0, -1, 20, 0);
    append_file(1, 1, 16'(PIX_DEPTH), 0, 8'hFF, HDR_LEN + image_bytes(1, 1), 3);
    append_file(2, 2, 16'(PIX_DEPTH), 0, 8'h00, HDR_LEN + image_bytes(2, 2), 0);
    // restart inside pixel data
    append_file(3, 1, 16'(PIX_DEPTH), 0, -1, HDR_LEN + 4, 0);
    // rejections: depth, compression, width overflow, negative height
    append_file(5, 2, 16'd32, 0, -1, HDR_LEN, 5);
    append_file(4, 1, 16'(PIX_DEPTH), 1, -1, HDR_LEN, 3);
    append_file(32'h0001_0000, 1, 16'(PIX_DEPTH), 0, -1, HDR_LEN, 2);
    append_file(2, 32'hFFFF_FFFE, 16'(PIX_DEPTH), 0, -1, HDR_LEN, 2);
    // largest accepted size, cut short by the next file
    append_file(32'h0000_FFFF, 32'h0000_FFFF, 16'(PIX_DEPTH), 0, -1, HDR_LEN + 9, 0);
    // empty images, then a complete 7x3 image with trailing bytes
    append_file(0, 3, 16'(PIX_DEPTH), 0, -1, HDR_LEN, 4);
    append_file(4, 0, 16'(PIX_DEPTH), 0, -1, HDR_LEN, 2);
    append_file(7, 3, 16'(PIX_DEPTH), 0, -1, HDR_LEN + image_bytes(7, 3), 2);
    wait_drained();

    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) tx_burst = !tx_burst;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        w = $urandom_range(1, 7);
        h = $urandom_range(1, 4);
        if ($urandom_range(0, 19) == 0) w = $urandom_range(8, 40);
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1) == 1) w = 0;
          else h = 0;
        end
        full = HDR_LEN + image_bytes(w, h);
        cut  = ($urandom_range(0, 6) == 0) ? $urandom_range(1, full) : full;
        append_file(w, h, 16'(PIX_DEPTH), 0, -1, cut, $urandom_range(0, 3));
      end else if (pick < 80) begin
        big_w = $urandom_range(1, 7);
        big_h = $urandom_range(1, 4);
        bpp   = 16'(PIX_DEPTH);
        cmp   = '0;
        case ($urandom_range(0, 3))
          0: begin
            bpp = 16'($urandom);
            if (bpp == 16'(PIX_DEPTH)) bpp = 16'd25;
          end
          1: begin
            cmp = $urandom;
            if (cmp == '0) cmp = 32'd1;
          end
          2: big_w = $urandom | 32'h0001_0000;
          default: big_h = $urandom | 32'h8000_0000;
        endcase
        append_file(big_w, big_h, bpp, cmp, -1, HDR_LEN, $urandom_range(0, 8));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom), $urandom_range(0, 9) == 0);
        end
      end else begin
        big_w = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 65535);
        big_h = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 65535);
        append_file(big_w, big_h, 16'(PIX_DEPTH), 0, -1, HDR_LEN + $urandom_range(0, 30), 0);
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    $display("Streamed %0d bytes in %0d files, with idle noise, restarts and truncation.",
             bytes_sent, files_sent);
    $display("Checked %0d accepted headers, %0d rejected headers and %0d pixels.",
             n_accepts, n_rejects, n_pixels);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
